// ===== rtl/hbc_pkg.sv =====
// Shared constants and bit-placement functions for the Hamming 40/32 byte codec.
// No dependencies; imported by hamming_32_40_byte_codec.
`default_nettype none

package hbc_pkg;

	localparam int CODE_W    = 40;
	localparam int DATA_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int CNT_W     = 3;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [CNT_W-1:0] ENC_GROUP = 3'd4;
	localparam logic [CNT_W-1:0] DEC_GROUP = 3'd5;
	localparam logic [CNT_W-1:0] OUT_ENC   = 3'd5;
	localparam logic [CNT_W-1:0] OUT_DEC   = 3'd4;
	localparam logic [CNT_W-1:0] OUT_ERR   = 3'd1;

	localparam logic [PADDR_W-1:0] ADDR_DECODE_MODE = 3'd0;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [DATA_W-1:0] word_t;

	// Positions count from the top bit: position p is bit CODE_W-1-p.
	function automatic logic not_data_pos(input int pos);
		return (pos == 0) || (pos == 1) || (pos == 2) || (pos == 4) || (pos == 8) ||
			(pos == 16) || (pos == 32) || (pos == CODE_W - 1);
	endfunction

	function automatic code_t spread_word(input word_t word);
		code_t code;
		int    src;
		code = '0;
		src  = DATA_W - 1;
		for (int pos = 0; pos < CODE_W; pos++) begin
			if (!not_data_pos(pos) && src >= 0) begin
				code[CODE_W-1-pos] = word[src];
				src--;
			end
		end
		return code;
	endfunction

	// Parity 2^i covers every position with bit i set in its index.
	function automatic code_t add_parity(input code_t code);
		code_t res;
		logic  par;
		res = code;
		for (int i = 0; i < 6; i++) begin
			par = 1'b0;
			for (int pos = 0; pos < CODE_W; pos++) begin
				if ((pos & (1 << i)) != 0)
					par = par ^ code[CODE_W-1-pos];
			end
			res[CODE_W-1-(1 << i)] = par;
		end
		return res;
	endfunction

	function automatic word_t gather_data(input code_t code);
		word_t word;
		int    dst;
		word = '0;
		dst  = DATA_W - 1;
		for (int pos = 0; pos < CODE_W; pos++) begin
			if (!not_data_pos(pos) && dst >= 0) begin
				word[dst] = code[CODE_W-1-pos];
				dst--;
			end
		end
		return word;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hamming_32_40_byte_codec.sv =====
// Top level of the Hamming 40/32 byte stream codec: APB mode register, byte
// gathering, encode/strip logic and the result shift buffer. Depends on hbc_pkg.
//
//  channel  | valid      | ready      | payload
//  ---------+------------+------------+-----------------------------------------
//  input    | byte_valid | byte_ready | data_byte, end_of_stream
//  result   | res_valid  | res_ready  | out_byte, last_of_run, length_error
//  config   | psel/penable/pwrite | pready=1 | paddr, pwdata, prdata
//
// A byte that closes a group is encoded or stripped in the cycle it is taken,
// straight into the result buffer, which then shifts out one byte per cycle
// while res_ready is high (5 in encode, 4 in decode, 1 on a length error).
// A group-closing byte waits only until the result buffer is empty; earlier
// bytes of a group are taken while the buffer still drains.
// Reset clears the mode (encode) and the gathered bytes and empties the result buffer.
`default_nettype none

module hamming_32_40_byte_codec
	import hbc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               byte_valid,
	output logic                    byte_ready,
	input  wire logic [BYTE_W-1:0]  data_byte,
	input  wire logic               end_of_stream,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic      [BYTE_W-1:0]  out_byte,
	output logic                    last_of_run,
	output logic                    length_error
);

	logic              mode_q;
	code_t             acc_q;
	logic [CNT_W-1:0]  cnt_q;
	code_t             ob_q;
	logic [CNT_W-1:0]  ob_cnt_q;
	logic              ob_err_q;

	logic              cfg_wr;
	logic              in_acc;
	logic              out_acc;
	code_t             acc_nxt;
	logic [CNT_W-1:0]  n_nxt;
	logic [CNT_W-1:0]  group;
	logic              emit;
	word_t             enc_word;
	code_t             enc_code;
	word_t             dec_word;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_DECODE_MODE);
	assign prdata = (paddr == ADDR_DECODE_MODE) ? {{(PDATA_W-1){1'b0}}, mode_q} : '0;

	assign acc_nxt = {acc_q[CODE_W-BYTE_W-1:0], data_byte};
	assign n_nxt   = cnt_q + 3'd1;
	assign group   = mode_q ? DEC_GROUP : ENC_GROUP;
	assign emit    = (n_nxt >= group) || end_of_stream;

	// A non-closing byte only accumulates; a closing one needs an empty buffer.
	assign byte_ready = !emit || (ob_cnt_q == '0);
	assign in_acc     = byte_valid && byte_ready;

	assign res_valid    = (ob_cnt_q != '0);
	assign out_acc      = res_valid && res_ready;
	assign out_byte     = ob_q[CODE_W-1 -: BYTE_W];
	assign last_of_run  = (ob_cnt_q == 3'd1);
	assign length_error = ob_err_q;

	// Zero-pad a short final group at the low end of the data word.
	always_comb begin
		case (n_nxt)
			3'd1:    enc_word = {acc_nxt[7:0], 24'b0};
			3'd2:    enc_word = {acc_nxt[15:0], 16'b0};
			3'd3:    enc_word = {acc_nxt[23:0], 8'b0};
			default: enc_word = acc_nxt[DATA_W-1:0];
		endcase
	end

	assign enc_code = add_parity(spread_word(enc_word));
	assign dec_word = gather_data(acc_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (cfg_wr) begin
			mode_q <= pwdata[0];
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (in_acc) begin
			if (emit) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_nxt;
				cnt_q <= n_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= '0;
			ob_err_q <= 1'b0;
		end else if (in_acc && emit) begin
			if (!mode_q) begin
				ob_cnt_q <= OUT_ENC;
				ob_err_q <= 1'b0;
			end else if (n_nxt < DEC_GROUP) begin
				ob_cnt_q <= OUT_ERR;
				ob_err_q <= 1'b1;
			end else begin
				ob_cnt_q <= OUT_DEC;
				ob_err_q <= 1'b0;
			end
		end else if (out_acc) begin
			ob_cnt_q <= ob_cnt_q - 3'd1;
			if (ob_cnt_q == 3'd1)
				ob_err_q <= 1'b0;
		end
	end

	// Payload buffer: load a whole word, then advance one byte per taken result.
	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			if (!mode_q)
				ob_q <= enc_code;
			else if (n_nxt < DEC_GROUP)
				ob_q <= '0;
			else
				ob_q <= {dec_word, {BYTE_W{1'b0}}};
		end else if (out_acc) begin
			ob_q <= {ob_q[CODE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
		end
	end

`ifndef NO_ASSERTIONS
	a_ob_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q <= OUT_ENC)
		else $error("result buffer count out of range");

	a_gather_below_group: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < group || cnt_q == '0)
		else $error("gathered byte count reached a full group without emitting");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		ob_err_q |-> (ob_cnt_q == 3'd1))
		else $error("length error result is not a single last word");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && emit && !cfg_wr) |=> (ob_cnt_q != '0))
		else $error("group-closing word did not load the result buffer");
`endif

endmodule

`default_nettype wire
